// ===== design/error_record_ring_log_unit_macros.svh =====
// Assertion macros for the error record ring log checker.
// No dependencies; included by the checker file.
`ifndef ERROR_RECORD_RING_LOG_UNIT_MACROS_SVH
`define ERROR_RECORD_RING_LOG_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ERLU_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ring log check failed");

// Next-cycle implication, disabled during reset.
`define ERLU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ring log check failed");

`endif

// ===== design/erlu_pkg.sv =====
// Shared constants and types for the error record ring log.
// No dependencies; used by the top level, erlu_ctrl and the checker.
`timescale 1ns / 1ps

package erlu_pkg;

    localparam int LOG_DEPTH = 16;
    localparam int PTR_W     = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
    localparam int CNT_W     = 5;
    localparam int IDX_W     = 8;
    localparam int REC_W     = 40;

    typedef enum logic
    {
        OP_REPORT = 1'b0,
        OP_READ   = 1'b1
    } op_t;

    typedef enum logic
    {
        ST_OK     = 1'b0,
        ST_NOT_OK = 1'b1
    } status_t;

    // Control from the pointer unit to the storage and result stage
    typedef struct packed
    {
        logic             wr_en;
        logic             rd_en;
        logic [PTR_W-1:0] addr;
        status_t          status;
        logic [CNT_W-1:0] count;
    } ring_ctl_t;

endpackage

// ===== design/error_record_ring_log_unit.sv =====
// Error record ring log: one item (report or read) accepted every cycle, busy never rises.
// The result strobes on done in the cycle after start is taken.
// Throughput: one item per cycle, set by the single-port record RAM (at most one access per item).
// Reset (rst_n low, async): pointer, count and wrapped flag clear; records stay undefined.
// Results cannot be stalled; each stands on the ports for one cycle.
// Depends on erlu_pkg, erlu_ctrl and erlu_ram.
`timescale 1ns / 1ps

module error_record_ring_log_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        opcode,
    input  logic [15:0] module_id,
    input  logic [7:0]  instance_id,
    input  logic [7:0]  api_id,
    input  logic [7:0]  error_id,
    input  logic [7:0]  read_index,
    output logic        done,
    output logic        status,
    output logic [4:0]  log_count,
    output logic [15:0] rd_module_id,
    output logic [7:0]  rd_instance_id,
    output logic [7:0]  rd_api_id,
    output logic [7:0]  rd_error_id
);

    // Every beat is taken as it arrives, so the block is never busy.
    logic accept;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    erlu_pkg::ring_ctl_t ctl;

    // Pointer/count bookkeeping and slot decode (oldest entry is index 0).
    erlu_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .opcode     (erlu_pkg::op_t'(opcode)),
        .read_index (read_index),
        .ctl        (ctl)
    );

    // Record layout: module id in the top 16 bits, then instance, api, error.
    logic [erlu_pkg::REC_W-1:0] wr_rec;
    logic [erlu_pkg::REC_W-1:0] rd_rec;
    assign wr_rec = {module_id, instance_id, api_id, error_id};

    // The registered read port doubles as the result register for the record.
    erlu_ram #(
        .WIDTH (erlu_pkg::REC_W),
        .DEPTH (erlu_pkg::LOG_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ctl.wr_en),
        .re    (ctl.rd_en),
        .addr  (ctl.addr),
        .wdata (wr_rec),
        .rdata (rd_rec)
    );

    // Result stage: strobe, status, count and a flag that gates the record fields.
    logic                       done_reg, done_next;
    erlu_pkg::status_t          status_reg;
    logic [erlu_pkg::CNT_W-1:0] count_reg;
    logic                       hit_reg;

    assign done_next = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    // Payload registers; only meaningful while done is high.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= ctl.status;
            count_reg  <= ctl.count;
            hit_reg    <= ctl.rd_en;
        end
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign log_count      = count_reg;
    // Reports and out-of-range reads return zero record fields.
    assign rd_module_id   = hit_reg ? rd_rec[39:24] : '0;
    assign rd_instance_id = hit_reg ? rd_rec[23:16] : '0;
    assign rd_api_id      = hit_reg ? rd_rec[15:8]  : '0;
    assign rd_error_id    = hit_reg ? rd_rec[7:0]   : '0;

endmodule

// ===== design/erlu_ram.sv =====
// Generic single-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps

module erlu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic             re,
    input  logic [AW-1:0]    addr,
    input  logic [WIDTH-1:0] wdata,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/erlu_ctrl.sv =====
// Write pointer, entry count and wrapped flag of the ring, plus slot decode.
// Depends on erlu_pkg.
`timescale 1ns / 1ps

module erlu_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  erlu_pkg::op_t              opcode,
    input  logic [erlu_pkg::IDX_W-1:0] read_index,
    output erlu_pkg::ring_ctl_t        ctl
);

    logic [erlu_pkg::PTR_W-1:0] wp_reg, wp_next;
    logic [erlu_pkg::CNT_W-1:0] count_reg, count_next;
    logic                       wrapped_reg, wrapped_next;

    logic [erlu_pkg::PTR_W:0]   wp_inc;
    logic                       wp_last;
    logic                       in_range;
    logic [erlu_pkg::PTR_W:0]   slot_sum;
    logic [erlu_pkg::PTR_W-1:0] slot;

    always_comb
    begin
        wp_inc   = {1'b0, wp_reg} + 1'b1;
        wp_last  = (wp_inc == (erlu_pkg::PTR_W + 1)'(erlu_pkg::LOG_DEPTH));
        in_range = ({{(erlu_pkg::IDX_W - erlu_pkg::CNT_W){1'b0}}, count_reg} > read_index);

        // idx < count <= depth, so one subtract folds the sum back into the ring
        slot_sum = {1'b0, wp_reg} + (erlu_pkg::PTR_W + 1)'(read_index);
        if (!wrapped_reg)
        begin
            slot = erlu_pkg::PTR_W'(read_index);
        end
        else if (slot_sum >= (erlu_pkg::PTR_W + 1)'(erlu_pkg::LOG_DEPTH))
        begin
            slot = erlu_pkg::PTR_W'(slot_sum - (erlu_pkg::PTR_W + 1)'(erlu_pkg::LOG_DEPTH));
        end
        else
        begin
            slot = erlu_pkg::PTR_W'(slot_sum);
        end
    end

    always_comb
    begin
        wp_next      = wp_reg;
        count_next   = count_reg;
        wrapped_next = wrapped_reg;
        ctl.wr_en    = 1'b0;
        ctl.rd_en    = 1'b0;
        ctl.addr     = slot;
        ctl.status   = erlu_pkg::ST_OK;
        if (accept)
        begin
            case (opcode)
                erlu_pkg::OP_REPORT:
                begin
                    ctl.wr_en = 1'b1;
                    ctl.addr  = wp_reg;
                    if (wp_last)
                    begin
                        wp_next      = '0;
                        wrapped_next = 1'b1;
                    end
                    else
                    begin
                        wp_next = erlu_pkg::PTR_W'(wp_inc);
                    end
                    count_next = (wp_last || wrapped_reg)
                               ? erlu_pkg::CNT_W'(erlu_pkg::LOG_DEPTH)
                               : erlu_pkg::CNT_W'(wp_inc);
                end
                default:
                begin
                    ctl.rd_en  = in_range;
                    ctl.status = in_range ? erlu_pkg::ST_OK : erlu_pkg::ST_NOT_OK;
                end
            endcase
        end
        ctl.count = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg      <= '0;
            count_reg   <= '0;
            wrapped_reg <= 1'b0;
        end
        else
        begin
            wp_reg      <= wp_next;
            count_reg   <= count_next;
            wrapped_reg <= wrapped_next;
        end
    end

endmodule

// ===== design/erlu_checker.sv =====
// Port-level checks for the error record ring log, bound to the top level.
// Depends on erlu_pkg and error_record_ring_log_unit_macros.svh.
`timescale 1ns / 1ps
`include "error_record_ring_log_unit_macros.svh"

module erlu_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        opcode,
    input logic        done,
    input logic        status,
    input logic [4:0]  log_count,
    input logic [15:0] rd_module_id,
    input logic [7:0]  rd_instance_id,
    input logic [7:0]  rd_api_id,
    input logic [7:0]  rd_error_id
);

    logic taken;
    logic fields_zero;
    assign taken       = start && !busy;
    assign fields_zero = (rd_module_id == 16'd0) && (rd_instance_id == 8'd0)
                      && (rd_api_id == 8'd0) && (rd_error_id == 8'd0);

    `ERLU_ASSERT_NEXT(a_one_result_per_beat, clk, rst_n, taken, done)
    `ERLU_ASSERT_NEXT(a_no_spurious_result, clk, rst_n, !taken, !done)
    `ERLU_ASSERT_NEXT(a_report_ok_nonempty, clk, rst_n,
        taken && (opcode == erlu_pkg::OP_REPORT),
        (status == erlu_pkg::ST_OK) && (log_count != 5'd0) && fields_zero)
    `ERLU_ASSERT_NOW(a_miss_zero_fields, clk, rst_n,
        done && (status == erlu_pkg::ST_NOT_OK), fields_zero)
    `ERLU_ASSERT_NOW(a_count_bounded, clk, rst_n,
        done, log_count <= erlu_pkg::CNT_W'(erlu_pkg::LOG_DEPTH))

endmodule

bind error_record_ring_log_unit erlu_checker u_erlu_checker (.*);

// ===== tb/tb_error_record_ring_log_unit.sv =====
// Self-checking testbench for error_record_ring_log_unit: directed table, then random beats.
// Depends on erlu_pkg and the block itself; a local model of the ring predicts each untyped result.
`timescale 1ns / 1ps

module tb_error_record_ring_log_unit;

    // Expected contents of one result beat
    typedef struct
    {
        erlu_pkg::status_t status;
        logic [4:0]        count;
        logic [15:0]       module_id;
        logic [7:0]        instance_id;
        logic [7:0]        api_id;
        logic [7:0]        error_id;
    } log_result_t;

    // One row of the directed table; typed rows carry their own answer
    typedef struct
    {
        erlu_pkg::op_t op;
        logic [15:0]   module_id;
        logic [7:0]    instance_id;
        logic [7:0]    api_id;
        logic [7:0]    error_id;
        logic [7:0]    read_index;
        bit            typed;
        log_result_t   answer;
    } log_row_t;

    logic          clk;
    logic          rst_n;
    logic          start;
    logic          busy;
    erlu_pkg::op_t opcode;
    logic [15:0]   module_id;
    logic [7:0]    instance_id;
    logic [7:0]    api_id;
    logic [7:0]    error_id;
    logic [7:0]    read_index;
    logic          done;
    logic          status;
    logic [4:0]    log_count;
    logic [15:0]   rd_module_id;
    logic [7:0]    rd_instance_id;
    logic [7:0]    rd_api_id;
    logic [7:0]    rd_error_id;

    // Local copy of the ring state
    logic [erlu_pkg::REC_W-1:0] ring_mirror [erlu_pkg::LOG_DEPTH];
    int                         mirror_wr_ptr;
    int                         mirror_fill;
    bit                         mirror_wrapped;

    log_result_t pending_results[$];
    log_row_t    directed_rows[$];
    log_result_t seen_expect;

    int  mismatches;
    int  n_reports;
    int  n_reads_hit;
    int  n_reads_miss;
    int  n_wraps;
    bit  idle_enable;

    error_record_ring_log_unit i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .opcode         (opcode),
        .module_id      (module_id),
        .instance_id    (instance_id),
        .api_id         (api_id),
        .error_id       (error_id),
        .read_index     (read_index),
        .done           (done),
        .status         (status),
        .log_count      (log_count),
        .rd_module_id   (rd_module_id),
        .rd_instance_id (rd_instance_id),
        .rd_api_id      (rd_api_id),
        .rd_error_id    (rd_error_id)
    );

    // 4 ns clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Hard stop in case the block hangs; a correct run needs only a few microseconds
    initial
    begin
        #200_000;
        $display("Some tests failed");
        $finish;
    end

    // Advance the local ring by one beat and return what the block must answer.
    // Reports always succeed and carry zero read fields; a read is rejected
    // unless its index falls below the current fill level.
    function automatic log_result_t predict_log_item(erlu_pkg::op_t op, logic [15:0] m,
                                                     logic [7:0] inst, logic [7:0] api,
                                                     logic [7:0] err, logic [7:0] idx);
        log_result_t                r;
        int                         slot;
        logic [erlu_pkg::REC_W-1:0] rec;
        r.status      = erlu_pkg::ST_OK;
        r.module_id   = '0;
        r.instance_id = '0;
        r.api_id      = '0;
        r.error_id    = '0;
        if (op == erlu_pkg::OP_REPORT)
        begin
            ring_mirror[mirror_wr_ptr] = {m, inst, api, err};
            if (mirror_wr_ptr == erlu_pkg::LOG_DEPTH - 1)
            begin
                mirror_wr_ptr  = 0;
                mirror_wrapped = 1'b1;
                n_wraps++;
            end
            else
            begin
                mirror_wr_ptr++;
            end
            mirror_fill = mirror_wrapped ? erlu_pkg::LOG_DEPTH : mirror_wr_ptr;
            n_reports++;
        end
        else if (int'(idx) >= mirror_fill)
        begin
            r.status = erlu_pkg::ST_NOT_OK;
            n_reads_miss++;
        end
        else
        begin
            // Once wrapped, the oldest entry sits at the write pointer
            slot = mirror_wrapped ? (mirror_wr_ptr + int'(idx)) % erlu_pkg::LOG_DEPTH
                                  : int'(idx);
            rec  = ring_mirror[slot];
            {r.module_id, r.instance_id, r.api_id, r.error_id} = rec;
            n_reads_hit++;
        end
        r.count = mirror_fill[4:0];
        return r;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("[%0t] %s mismatch: expected %h, got %h", $realtime, name, want, got);
        end
    endtask

    // Result beats strobe on done and cannot be held off; each is matched
    // against the oldest outstanding expectation.
    always @(posedge clk)
    begin
        if (rst_n && done === 1'b1)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] result beat with nothing expected", $realtime);
            end
            else
            begin
                seen_expect = pending_results.pop_front();
                check_field("status", 16'(seen_expect.status), 16'(status));
                check_field("log_count", 16'(seen_expect.count), 16'(log_count));
                check_field("rd_module_id", seen_expect.module_id, rd_module_id);
                check_field("rd_instance_id", 16'(seen_expect.instance_id), 16'(rd_instance_id));
                check_field("rd_api_id", 16'(seen_expect.api_id), 16'(rd_api_id));
                check_field("rd_error_id", 16'(seen_expect.error_id), 16'(rd_error_id));
            end
        end
    end

    // Random gap before a beat: the sender keeps idling while a draw from 0 to 99 falls below 11
    task automatic sender_gap();
        while (idle_enable && $urandom_range(0, 99) < 11)
        begin
            @(negedge clk);
            start = 1'b0;
        end
    endtask

    // Present one beat at the falling edge and hold it until the block takes it.
    // A typed answer replaces the prediction, but the local ring still advances.
    task automatic send_beat(log_row_t row);
        log_result_t predicted;
        sender_gap();
        @(negedge clk);
        start       = 1'b1;
        opcode      = row.op;
        module_id   = row.module_id;
        instance_id = row.instance_id;
        api_id      = row.api_id;
        error_id    = row.error_id;
        read_index  = row.read_index;
        do
            @(posedge clk);
        while (busy);
        predicted = predict_log_item(row.op, row.module_id, row.instance_id, row.api_id,
                                     row.error_id, row.read_index);
        pending_results.push_back(row.typed ? row.answer : predicted);
    endtask

    task automatic add_row(erlu_pkg::op_t op, logic [15:0] m, logic [7:0] inst,
                           logic [7:0] api, logic [7:0] err, logic [7:0] idx, bit typed,
                           erlu_pkg::status_t st, logic [4:0] cnt, logic [15:0] rm,
                           logic [7:0] ri, logic [7:0] ra, logic [7:0] re);
        log_row_t row;
        row.op                 = op;
        row.module_id          = m;
        row.instance_id        = inst;
        row.api_id             = api;
        row.error_id           = err;
        row.read_index         = idx;
        row.typed              = typed;
        row.answer.status      = st;
        row.answer.count       = cnt;
        row.answer.module_id   = rm;
        row.answer.instance_id = ri;
        row.answer.api_id      = ra;
        row.answer.error_id    = re;
        directed_rows.push_back(row);
    endtask

    // Random beat: reports and reads in equal share; most indices lie between 0 and one past the depth
    // so hits and the boundary both show up, with some indices across the whole range.
    function automatic log_row_t random_row();
        log_row_t row;
        row.op          = ($urandom_range(0, 99) < 50) ? erlu_pkg::OP_REPORT
                                                       : erlu_pkg::OP_READ;
        row.module_id   = 16'($urandom_range(0, 65535));
        row.instance_id = 8'($urandom_range(0, 255));
        row.api_id      = 8'($urandom_range(0, 255));
        row.error_id    = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 70)
            row.read_index = 8'($urandom_range(0, erlu_pkg::LOG_DEPTH + 1));
        else
            row.read_index = 8'($urandom_range(0, 255));
        row.typed = 1'b0;
        return row;
    endfunction

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        // Every input known from time zero
        rst_n          = 1'b0;
        start          = 1'b0;
        opcode         = erlu_pkg::OP_REPORT;
        module_id      = '0;
        instance_id    = '0;
        api_id         = '0;
        error_id       = '0;
        read_index     = '0;
        mismatches     = 0;
        n_reports      = 0;
        n_reads_hit    = 0;
        n_reads_miss   = 0;
        n_wraps        = 0;
        mirror_wr_ptr  = 0;
        mirror_fill    = 0;
        mirror_wrapped = 1'b0;
        idle_enable    = 1'b1;
        foreach (ring_mirror[k])
            ring_mirror[k] = '0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table.
        // Empty log: reads at both ends of the index range are rejected.
        add_row(erlu_pkg::OP_READ, 16'h0000, 8'h00, 8'h00, 8'h00, 8'd0, 1,
                erlu_pkg::ST_NOT_OK, 5'd0, 16'h0000, 8'h00, 8'h00, 8'h00);
        add_row(erlu_pkg::OP_READ, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'd255, 1,
                erlu_pkg::ST_NOT_OK, 5'd0, 16'h0000, 8'h00, 8'h00, 8'h00);
        // Extreme records, then read both back before the ring wraps
        add_row(erlu_pkg::OP_REPORT, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'd0, 1,
                erlu_pkg::ST_OK, 5'd1, 16'h0000, 8'h00, 8'h00, 8'h00);
        add_row(erlu_pkg::OP_REPORT, 16'h0000, 8'h00, 8'h00, 8'h00, 8'hFF, 1,
                erlu_pkg::ST_OK, 5'd2, 16'h0000, 8'h00, 8'h00, 8'h00);
        add_row(erlu_pkg::OP_READ, 16'h0000, 8'h00, 8'h00, 8'h00, 8'd0, 1,
                erlu_pkg::ST_OK, 5'd2, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
        add_row(erlu_pkg::OP_READ, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF, 8'd1, 1,
                erlu_pkg::ST_OK, 5'd2, 16'h0000, 8'h00, 8'h00, 8'h00);
        // Index equal to the count is just out of range
        add_row(erlu_pkg::OP_READ, 16'h0000, 8'h00, 8'h00, 8'h00, 8'd2, 1,
                erlu_pkg::ST_NOT_OK, 5'd2, 16'h0000, 8'h00, 8'h00, 8'h00);
        // Fill to the depth; the last of these wraps the pointer
        for (int k = 0; k < erlu_pkg::LOG_DEPTH - 2; k++)
            add_row(erlu_pkg::OP_REPORT, 16'(16'h1001 * (k + 1)), 8'(8'h21 + k),
                    8'(8'h42 + k), 8'(8'h84 + k), 8'(k), 0, erlu_pkg::ST_OK, 5'd0,
                    16'h0000, 8'h00, 8'h00, 8'h00);
        // Full ring: oldest entry is overwritten, count stays at the depth
        add_row(erlu_pkg::OP_REPORT, 16'hA5A5, 8'h5A, 8'hC3, 8'h3C, 8'd0, 0,
                erlu_pkg::ST_OK, 5'd0, 16'h0000, 8'h00, 8'h00, 8'h00);
        add_row(erlu_pkg::OP_READ, 16'h0000, 8'h00, 8'h00, 8'h00, 8'd0, 0,
                erlu_pkg::ST_OK, 5'd0, 16'h0000, 8'h00, 8'h00, 8'h00);
        add_row(erlu_pkg::OP_READ, 16'h0000, 8'h00, 8'h00, 8'h00,
                8'(erlu_pkg::LOG_DEPTH - 1), 0, erlu_pkg::ST_OK, 5'd0,
                16'h0000, 8'h00, 8'h00, 8'h00);
        add_row(erlu_pkg::OP_READ, 16'h0000, 8'h00, 8'h00, 8'h00,
                8'(erlu_pkg::LOG_DEPTH), 1, erlu_pkg::ST_NOT_OK, 5'(erlu_pkg::LOG_DEPTH),
                16'h0000, 8'h00, 8'h00, 8'h00);

        foreach (directed_rows[k])
            send_beat(directed_rows[k]);

        // Sender holds off until the directed answers are all in
        @(negedge clk);
        start = 1'b0;
        wait_drained();

        // Random beats; one long stretch runs back to back, and the sender
        // pauses once more in the middle until the log has answered everything.
        for (int n = 0; n < 800; n++)
        begin
            idle_enable = !(n >= 200 && n < 450);
            if (n == 500)
            begin
                @(negedge clk);
                start = 1'b0;
                wait_drained();
            end
            send_beat(random_row());
        end

        @(negedge clk);
        start = 1'b0;

        // Drain, then wait for any stray result beat before the final check
        wait_drained();
        repeat (4) @(posedge clk);

        if (pending_results.size() != 0)
            mismatches++;

        $display("Run covered %0d reports, %0d read hits and %0d rejected reads,",
                 n_reports, n_reads_hit, n_reads_miss);
        $display("with the ring wrapping %0d times; %0d mismatches seen.", n_wraps, mismatches);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
